@@ sv/sdc_pkg.sv @@
// Shared types, constants and digit helpers for the settable 24-hour clock.
package sdc_pkg;

   // Counter limits.
   localparam logic [5:0] SEC_PER_MIN   = 6'd60;
   localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
   localparam logic [5:0] HOURS_PER_DAY = 6'd24;

   // Edge flag bit positions.
   localparam int unsigned EDGE_MIN_UP   = 0;
   localparam int unsigned EDGE_HOUR_UP  = 1;
   localparam int unsigned EDGE_MIN_DOWN = 2;
   localparam int unsigned EDGE_HOUR_DOWN = 3;

   // Display reset patterns.
   localparam logic [7:0] ONES_RESET = 8'h00;
   localparam logic [7:0] TENS_RESET = 8'hFF;

   // Input beat.
   typedef struct packed {
      logic op;
      logic hour_select;
      logic up_level;
      logic down_level;
      logic start_level;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [7:0] ones_pattern;
      logic [7:0] tens_pattern;
      logic [4:0] hours_now;
      logic [5:0] minutes_now;
      logic [5:0] seconds_now;
      logic [3:0] lamp_flags;
      logic       running;
   } rsp_type;

   // Architectural state of the clock.
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       run_mode;
      logic [3:0] edge_flags;
      logic [1:0] show_count;
      logic [7:0] shown_ones;
      logic [7:0] shown_tens;
      logic [3:0] lamps;
   } state_type;

   // Two displayed digit patterns.
   typedef struct packed {
      logic [7:0] tens;
      logic [7:0] ones;
   } disp_type;

   // Seven-segment pattern of one decimal digit.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'hDB;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'hFF;
         4'd9:    pat = 8'h6F;
         default: pat = 8'h3F;
      endcase
      return pat;
   endfunction

   // Tens digit of a value below 64, by comparison.
   function automatic logic [2:0] tens_digit(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   // Ones digit of a value below 64.
   function automatic logic [3:0] ones_digit(input logic [5:0] v);
      logic [5:0] tens10;
      logic [5:0] rem;
      tens10 = 6'({3'd0, tens_digit(v)} * 6'd10);
      rem    = v - tens10;
      return rem[3:0];
   endfunction

   // Patterns for a two-digit value.
   function automatic disp_type show_value(input logic [5:0] v);
      disp_type d;
      d.ones = seg_pattern(ones_digit(v));
      d.tens = seg_pattern({1'b0, tens_digit(v)});
      return d;
   endfunction

endpackage

@@ sv/sdc_step.sv @@
// Next-state logic of the clock for one input beat.
module sdc_step
   import sdc_pkg::*;
(
   input  state_type cur,
   input  req_type   item,
   output state_type nxt
);

   typedef struct packed {
      logic [5:0] value;
      logic       up_flag;
      logic       down_flag;
   } field_type;

   // One set-mode step of a field: up edge with wrap, then down edge with wrap.
   function automatic field_type step_field(input logic [5:0] v_in, input logic [5:0] limit,
                                            input logic up, input logic down,
                                            input logic up_flag, input logic down_flag);
      field_type  r;
      logic [5:0] v;
      v           = v_in;
      r.up_flag   = up_flag;
      r.down_flag = down_flag;
      if (up && !up_flag) begin
         r.up_flag = 1'b1;
         v         = v + 6'd1;
      end
      if (!up) r.up_flag = 1'b0;
      if (v >= limit) v = '0;
      if (down && !down_flag) begin
         r.down_flag = 1'b1;
         v           = (v == 6'd0) ? limit - 6'd1 : v - 6'd1;
      end
      if (!down) r.down_flag = 1'b0;
      r.value = v;
      return r;
   endfunction

   field_type  hour_step;
   field_type  min_step;
   disp_type   hour_disp;
   disp_type   min_disp;
   disp_type   tick_min_disp;
   disp_type   tick_hour_disp;
   disp_type   tick_sec_disp;
   logic [5:0] sec_inc;
   logic [5:0] min_inc;
   logic [5:0] hour_inc;
   logic [1:0] count_inc;
   logic [3:0] sec_ones;
   logic [4:0] hr;

   // Field steps and displays for set mode.
   assign hour_step = step_field({1'b0, cur.hours}, HOURS_PER_DAY, item.up_level,
                                 item.down_level, cur.edge_flags[EDGE_HOUR_UP],
                                 cur.edge_flags[EDGE_HOUR_DOWN]);
   assign min_step  = step_field(cur.minutes, MIN_PER_HOUR, item.up_level,
                                 item.down_level, cur.edge_flags[EDGE_MIN_UP],
                                 cur.edge_flags[EDGE_MIN_DOWN]);
   assign hour_disp = show_value({1'b0, cur.hours});
   assign min_disp  = show_value(cur.minutes);

   // Time advance for a tick.
   always_comb begin
      sec_inc  = cur.seconds + 6'd1;
      min_inc  = cur.minutes;
      hour_inc = {1'b0, cur.hours};
      if (sec_inc == SEC_PER_MIN) begin
         sec_inc = '0;
         min_inc = min_inc + 6'd1;
      end
      if (min_inc == MIN_PER_HOUR) begin
         min_inc  = '0;
         hour_inc = hour_inc + 6'd1;
      end
      if (hour_inc == HOURS_PER_DAY) begin
         hour_inc = '0;
         min_inc  = '0;
      end
   end

   assign hr             = hour_inc[4:0];
   assign sec_ones       = ones_digit(sec_inc);
   assign count_inc      = cur.show_count + 2'd1;
   assign tick_min_disp  = show_value(min_inc);
   assign tick_hour_disp = show_value(hour_inc);
   assign tick_sec_disp  = show_value(sec_inc);

   // Select the update for this beat.
   always_comb begin
      nxt = cur;
      if (!cur.run_mode && !item.op) begin
         if (item.hour_select) begin
            nxt.shown_ones                 = hour_disp.ones;
            nxt.shown_tens                 = hour_disp.tens;
            nxt.hours                      = hour_step.value[4:0];
            nxt.edge_flags[EDGE_HOUR_UP]   = hour_step.up_flag;
            nxt.edge_flags[EDGE_HOUR_DOWN] = hour_step.down_flag;
         end else begin
            nxt.shown_ones                = min_disp.ones;
            nxt.shown_tens                = min_disp.tens;
            nxt.minutes                   = min_step.value;
            nxt.edge_flags[EDGE_MIN_UP]   = min_step.up_flag;
            nxt.edge_flags[EDGE_MIN_DOWN] = min_step.down_flag;
         end
         if (!item.start_level) nxt.run_mode = 1'b1;
      end else if (cur.run_mode && item.op) begin
         nxt.seconds = sec_inc;
         nxt.minutes = min_inc;
         nxt.hours   = hr;
         // Lamps light for hours divisible by 2, 3, 5 and 8.
         nxt.lamps[0] = ~hr[0];
         nxt.lamps[1] = (hr == 5'd0) || (hr == 5'd3) || (hr == 5'd6) || (hr == 5'd9) ||
                        (hr == 5'd12) || (hr == 5'd15) || (hr == 5'd18) || (hr == 5'd21);
         nxt.lamps[2] = (hr == 5'd0) || (hr == 5'd5) || (hr == 5'd10) || (hr == 5'd15) ||
                        (hr == 5'd20);
         nxt.lamps[3] = (hr[2:0] == 3'd0);
         // Seconds normally; minutes on multiples of five, hours on every second one.
         if (sec_ones == 4'd0 || sec_ones == 4'd5) begin
            if (count_inc == 2'd2) begin
               nxt.show_count = 2'd0;
               nxt.shown_ones = tick_hour_disp.ones;
               nxt.shown_tens = tick_hour_disp.tens;
            end else begin
               nxt.show_count = count_inc;
               nxt.shown_ones = tick_min_disp.ones;
               nxt.shown_tens = tick_min_disp.tens;
            end
         end else begin
            nxt.shown_ones = tick_sec_disp.ones;
            nxt.shown_tens = tick_sec_disp.tens;
         end
      end
   end

endmodule

@@ sv/settable_24h_clock_with_segment_display.sv @@
// Top level of the settable 24-hour clock with a two-digit segment display.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_data (req_type)
//   rsp_      out        rsp_valid/rsp_ready    rsp_data (rsp_type)
//
// Each beat passes through the input register, then the next-state logic writes
// the state and result registers.
// One beat is accepted per cycle while the result side keeps taking beats.
// Reset clears the time, mode and edge flags; the display takes its reset patterns.
// A stalled result holds the pipe; the input register still takes one beat.
module settable_24h_clock_with_segment_display
   import sdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      in_valid_ff;
   req_type   in_item_ff;
   logic      out_valid_ff;
   rsp_type   out_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   out_in;
   logic      fire;

   // The input beat moves on when the result register is free or draining.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   sdc_step u_step (
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in)
   );

   // Result beat built from the state after the step.
   always_comb begin
      out_in.ones_pattern = state_in.shown_ones;
      out_in.tens_pattern = state_in.shown_tens;
      out_in.hours_now    = state_in.hours;
      out_in.minutes_now  = state_in.minutes;
      out_in.seconds_now  = state_in.seconds;
      out_in.lamp_flags   = state_in.lamps;
      out_in.running      = state_in.run_mode;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) in_item_ff <= req_data;
   end

   // Clock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hours      <= '0;
         state_ff.minutes    <= '0;
         state_ff.seconds    <= '0;
         state_ff.run_mode   <= 1'b0;
         state_ff.edge_flags <= '0;
         state_ff.show_count <= '0;
         state_ff.shown_ones <= ONES_RESET;
         state_ff.shown_tens <= TENS_RESET;
         state_ff.lamps      <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (fire) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ sv/sdc_checker.sv @@
// Port-level checks for the settable 24-hour clock, bound to the top level.
module sdc_checker
   import sdc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic seen_running_ff;

   // Tracks whether any result beat has reported run mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_running_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_data.running) begin
         seen_running_ff <= 1'b1;
      end
   end

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Run mode, once reported, is never left.
   a_run_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_running_ff |-> rsp_data.running)
      else $error("run mode left");

   // Time fields stay in range.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hours_now < 5'd24 && rsp_data.minutes_now < 6'd60 &&
                    rsp_data.seconds_now < 6'd60)
      else $error("time field out of range");

   // Before run mode, seconds and lamps never move.
   a_set_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.running |-> rsp_data.seconds_now == 6'd0 &&
                                         rsp_data.lamp_flags == 4'd0)
      else $error("time advanced in set mode");

endmodule

bind settable_24h_clock_with_segment_display sdc_checker u_sdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
